>>> design/pnm_stream_to_gray_macros.svh
// Assertion macros shared by the checker of pnm_stream_to_gray.
// No dependencies.
`ifndef PNM_STREAM_TO_GRAY_MACROS_SVH
`define PNM_STREAM_TO_GRAY_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define PNM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pnm check failed");

// Next-cycle implication under an active-low reset.
`define PNM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pnm check failed");

`endif

>>> design/pnm_s2g_pkg.sv
// Package for pnm_stream_to_gray: result codes, command and result types.
// No dependencies.
`default_nettype none
package pnm_s2g_pkg;

  localparam int unsigned MaxDimDefault = 16384;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_MAGIC  = 3'd1;
  localparam logic [2:0] ERR_CHAR   = 3'd2;
  localparam logic [2:0] ERR_DIM    = 3'd3;
  localparam logic [2:0] ERR_MAXVAL = 3'd4;

  typedef enum logic [1:0] {
    OP_DIRECT,
    OP_DIV,
    OP_UNPK,
    OP_THIRD
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [1:0]  kind;
    logic [7:0]  gray;
    logic [2:0]  err;
    logic [2:0]  fmt;
    logic [14:0] width;
    logic [14:0] height;
    logic [15:0] maxs;
    logic        done;
    logic [24:0] num;
    logic [16:0] divisor;
    logic [7:0]  bits;
    logic [3:0]  cnt;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  gray;
    logic [2:0]  format_digit;
    logic [14:0] width;
    logic [14:0] height;
    logic [15:0] max_sample;
    logic [2:0]  error_code;
    logic        image_done;
    logic        run_end;
  } res_t;

endpackage
`default_nettype wire

>>> design/pnm_s2g_if.sv
// Stream interfaces of pnm_stream_to_gray: file bytes in, results out.
// No dependencies.
`default_nettype none
interface pnm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;
  modport source (output valid, data_byte, start_of_file, input ready);
  modport sink   (input valid, data_byte, start_of_file, output ready);
endinterface

interface pnm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  gray;
  logic [2:0]  format_digit;
  logic [14:0] width;
  logic [14:0] height;
  logic [15:0] max_sample;
  logic [2:0]  error_code;
  logic        image_done;
  logic        run_end;
  modport source (output valid, kind, gray, format_digit, width, height, max_sample,
                  error_code, image_done, run_end, input ready);
  modport sink   (input valid, kind, gray, format_digit, width, height, max_sample,
                  error_code, image_done, run_end, output ready);
endinterface
`default_nettype wire

>>> design/pnm_s2g_front.sv
// Front end: parses header and data bytes, issues one command per result run.
// Depends on pnm_s2g_pkg.
`default_nettype none
module pnm_s2g_front #(
  parameter int unsigned MAX_DIM = pnm_s2g_pkg::MaxDimDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [7:0]        in_data_i,
  input  wire logic              in_sof_i,
  output logic                   in_ready_o,
  output logic                   cmd_valid_o,
  output pnm_s2g_pkg::cmd_t      cmd_o,
  input  wire logic              cmd_ready_i
);
  import pnm_s2g_pkg::*;

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);

  typedef enum logic [2:0] {
    PH_MAGIC_P, PH_MAGIC_D, PH_HEADER, PH_DATA, PH_DONE, PH_ERROR
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [2:0]      fmt_q, fmt_d;
  logic [DimW-1:0] wid_q, wid_d, hgt_q, hgt_d, col_q, col_d, row_q, row_d;
  logic [15:0]     mx_q, mx_d;
  logic [16:0]     acc_q, acc_d;
  logic [2:0]      step_q, step_d;
  logic            cmt_q, cmt_d;
  logic [17:0]     sum_q, sum_d;
  logic [1:0]      comp_q, comp_d;
  logic            bis_q, bis_d;

  logic            emit;
  cmd_t            cmd;
  logic [7:0]      c;
  logic            is_ws, is_dig;
  logic [19:0]     v_hdr;
  logic [20:0]     v_asc;
  logic [18:0]     sum_ext;
  logic [2:0]      target;
  logic [DimW-1:0] left;
  logic [3:0]      cnt;
  logic [DimW:0]   col_end;
  logic            pix;
  logic [7:0]      pix_gray;
  logic            ev_err, ev_hdr, ev_div, ev_unpk, ev_third;
  logic [2:0]      err_code;
  logic [24:0]     div_num;
  logic [16:0]     div_den;
  logic            unpk_done;
  logic            last;
  logic [7:0]      raw;

  assign in_ready_o = cmd_ready_i;
  assign c          = in_data_i;
  assign is_ws      = c inside {[8'd9:8'd13], 8'd32};
  assign is_dig     = c inside {[8'd48:8'd57]};

  always_comb begin
    phase_d = in_sof_i ? PH_MAGIC_P : phase_q;
    fmt_d   = in_sof_i ? 3'd0 : fmt_q;
    wid_d   = in_sof_i ? '0 : wid_q;
    hgt_d   = in_sof_i ? '0 : hgt_q;
    mx_d    = in_sof_i ? '0 : mx_q;
    acc_d   = in_sof_i ? '0 : acc_q;
    step_d  = in_sof_i ? '0 : step_q;
    cmt_d   = in_sof_i ? 1'b0 : cmt_q;
    col_d   = in_sof_i ? '0 : col_q;
    row_d   = in_sof_i ? '0 : row_q;
    sum_d   = in_sof_i ? '0 : sum_q;
    comp_d  = in_sof_i ? '0 : comp_q;
    bis_d   = in_sof_i ? 1'b0 : bis_q;
    pix = 1'b0; pix_gray = '0; ev_err = 1'b0; ev_hdr = 1'b0; ev_div = 1'b0;
    ev_unpk = 1'b0; ev_third = 1'b0; err_code = ERR_NONE; div_num = '0; div_den = '0;
    unpk_done = 1'b0; cnt = '0; left = '0; col_end = '0; raw = c;
    target  = (fmt_d == 3'd1 || fmt_d == 3'd4) ? 3'd4 : 3'd6;
    v_hdr   = 20'(acc_d) * 20'd10 + 20'(c - 8'd48);
    v_asc   = 21'(acc_d) * 21'd10 + 21'(c - 8'd48);
    sum_ext = 19'(sum_d) + 19'(acc_d);
    case (phase_d)
      PH_MAGIC_P: begin
        if (c == 8'h50) phase_d = PH_MAGIC_D;
        else begin ev_err = 1'b1; err_code = ERR_MAGIC; end
      end
      PH_MAGIC_D: begin
        if (c inside {[8'd49:8'd54]}) begin
          fmt_d = 3'(c - 8'd48); phase_d = PH_HEADER;
        end else begin ev_err = 1'b1; err_code = ERR_MAGIC; end
      end
      PH_HEADER, PH_DATA: begin
        if (phase_d == PH_HEADER || fmt_d <= 3'd3) begin
          if (cmt_d) begin
            if (c == 8'd10) cmt_d = 1'b0;
          end else if (c == 8'h23) begin
            cmt_d = 1'b1;
          end else if (phase_d == PH_HEADER) begin
            if (!step_d[0] && !is_ws) step_d = step_d + 3'd1;
            if (step_d[0]) begin
              if (is_dig) begin
                if (step_d == 3'd5 && v_hdr > 20'd65535) begin
                  ev_err = 1'b1; err_code = ERR_MAXVAL;
                end else if (step_d != 3'd5 && v_hdr > 20'(MAX_DIM)) begin
                  ev_err = 1'b1; err_code = ERR_DIM;
                end else acc_d = v_hdr[16:0];
              end else if (!is_ws) begin
                ev_err = 1'b1; err_code = ERR_CHAR;
              end else if (step_d == 3'd5 && acc_d == '0) begin
                ev_err = 1'b1; err_code = ERR_MAXVAL;
              end else begin
                if (step_d == 3'd1) wid_d = acc_d[DimW-1:0];
                else if (step_d == 3'd3) hgt_d = acc_d[DimW-1:0];
                else mx_d = acc_d[15:0];
                acc_d  = '0;
                step_d = step_d + 3'd1;
                if (step_d >= target) begin
                  if (target == 3'd4) mx_d = 16'd1;
                  step_d = '0; col_d = '0; row_d = '0; sum_d = '0;
                  comp_d = '0; bis_d = 1'b0; ev_hdr = 1'b1;
                  phase_d = (wid_d == '0 || hgt_d == '0) ? PH_DONE : PH_DATA;
                end
              end
            end
          end else begin
            if (is_dig) begin
              if (fmt_d == 3'd1) begin
                pix = 1'b1; pix_gray = (c == 8'd48) ? 8'd255 : 8'd0;
              end else begin
                acc_d  = (v_asc > 21'h1FFFF) ? 17'h1FFFF : v_asc[16:0];
                step_d = 3'd1;
              end
            end else if (!is_ws) begin
              ev_err = 1'b1; err_code = ERR_CHAR;
            end else if (fmt_d != 3'd1 && step_d != '0) begin
              if (fmt_d == 3'd2) begin
                pix = 1'b1; ev_div = 1'b1;
                div_num = 25'(acc_d) * 25'd255; div_den = 17'(mx_d);
              end else begin
                sum_d  = (sum_ext > 19'h3FFFF) ? 18'h3FFFF : sum_ext[17:0];
                comp_d = comp_d + 2'd1;
                if (comp_d == 2'd3) begin
                  pix = 1'b1; ev_third = 1'b1;
                  div_num = 25'(sum_d);
                  sum_d = '0; comp_d = '0;
                end
              end
              acc_d = '0; step_d = '0;
            end
          end
        end else if (fmt_d == 3'd4) begin
          left    = wid_d - col_d;
          cnt     = (left < DimW'(8)) ? left[3:0] : 4'd8;
          col_end = (DimW+1)'(col_d) + (DimW+1)'(cnt);
          ev_unpk = 1'b1;
          if (col_end >= (DimW+1)'(wid_d)) begin
            col_d = '0;
            if (row_d == hgt_d - 1'b1) begin unpk_done = 1'b1; phase_d = PH_DONE; end
            else row_d = row_d + 1'b1;
          end else col_d = col_end[DimW-1:0];
        end else begin
          if (mx_d > 16'd255 && !bis_d) begin
            bis_d = 1'b1; acc_d = 17'(c);
          end else begin
            if (mx_d > 16'd255) begin bis_d = 1'b0; raw = acc_d[7:0]; end
            if (fmt_d == 3'd5) begin pix = 1'b1; pix_gray = raw; end
            else begin
              sum_d  = sum_d + 18'(raw);
              comp_d = comp_d + 2'd1;
              if (comp_d == 2'd3) begin
                pix = 1'b1; ev_third = 1'b1;
                div_num = 25'(sum_d);
                sum_d = '0; comp_d = '0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (ev_err) phase_d = PH_ERROR;
    // advance the raster position for a single pixel
    last = 1'b0;
    if (pix) begin
      if (row_d == hgt_d - 1'b1 && col_d == wid_d - 1'b1) begin
        last = 1'b1; phase_d = PH_DONE;
      end else if (col_d == wid_d - 1'b1) begin
        col_d = '0; row_d = row_d + 1'b1;
      end else col_d = col_d + 1'b1;
    end
    emit        = ev_err || ev_hdr || pix || ev_unpk;
    cmd.op      = ev_unpk ? OP_UNPK : (ev_div ? OP_DIV : (ev_third ? OP_THIRD : OP_DIRECT));
    cmd.kind    = ev_err ? KIND_ERROR : (ev_hdr ? KIND_HEADER : KIND_PIXEL);
    cmd.gray    = pix_gray;
    cmd.err     = err_code;
    cmd.fmt     = fmt_d;
    cmd.width   = 15'(wid_d);
    cmd.height  = 15'(hgt_d);
    cmd.maxs    = mx_d;
    cmd.done    = last || unpk_done;
    cmd.num     = div_num;
    cmd.divisor = div_den;
    cmd.bits    = c;
    cmd.cnt     = cnt;
  end

  assign cmd_valid_o = in_valid_i && emit;
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC_P; fmt_q <= '0; wid_q <= '0; hgt_q <= '0; mx_q <= '0;
      acc_q <= '0; step_q <= '0; cmt_q <= 1'b0; col_q <= '0; row_q <= '0;
      sum_q <= '0; comp_q <= '0; bis_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      phase_q <= phase_d; fmt_q <= fmt_d; wid_q <= wid_d; hgt_q <= hgt_d; mx_q <= mx_d;
      acc_q <= acc_d; step_q <= step_d; cmt_q <= cmt_d; col_q <= col_d; row_q <= row_d;
      sum_q <= sum_d; comp_q <= comp_d; bis_q <= bis_d;
    end
  end
endmodule
`default_nettype wire

>>> design/pnm_s2g_queue.sv
// Two-entry command queue between the parser front and the pixel back end.
// Depends on pnm_s2g_pkg.
`default_nettype none
module pnm_s2g_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  pnm_s2g_pkg::cmd_t      data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output pnm_s2g_pkg::cmd_t      data_o,
  input  wire logic              pop_i
);
  import pnm_s2g_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

>>> design/pnm_s2g_back.sv
// Back end: divides, unpacks bitmap bytes and drives the result register.
// Depends on pnm_s2g_pkg.
`default_nettype none
module pnm_s2g_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  pnm_s2g_pkg::cmd_t      cmd_i,
  output logic                   cmd_ready_o,
  output logic                   out_valid_o,
  output pnm_s2g_pkg::res_t      out_o,
  input  wire logic              out_ready_i
);
  import pnm_s2g_pkg::*;

  typedef enum logic [1:0] {BK_IDLE, BK_DIV, BK_EMIT, BK_UNPK} bk_e;

  bk_e         state_q;
  cmd_t        w_q;
  logic [24:0] rem_q;
  logic [2:0]  step_q;
  logic [7:0]  quo_q;
  logic        out_vld_q;
  res_t        out_q;
  logic [24:0] trial;
  logic        hit;
  logic [7:0]  quo_nx;
  logic        slot_free;
  logic        emit_now;
  logic        sat;
  logic [35:0] third_prod;
  logic [7:0]  third_sat;

  assign trial       = 25'(w_q.divisor) << step_q;
  assign hit         = rem_q >= trial;
  assign quo_nx      = quo_q | (8'(hit) << step_q);
  assign slot_free   = !out_vld_q || out_ready_i;
  assign emit_now    = slot_free && (state_q == BK_EMIT || state_q == BK_UNPK);
  assign cmd_ready_o = (state_q == BK_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;
  // quotient of 256 or more saturates
  assign sat         = cmd_i.num >= {cmd_i.divisor, 8'd0};
  // divide by 3 as multiply by ceil(2^19 / 3), exact for sums below 2^19
  assign third_prod  = 36'(cmd_i.num[17:0]) * 36'd174763;
  assign third_sat   = (third_prod[35:27] != '0) ? 8'hFF : third_prod[26:19];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      if (emit_now) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
      case (state_q)
        BK_IDLE: begin
          if (cmd_valid_i) begin
            w_q    <= cmd_i;
            rem_q  <= cmd_i.num;
            quo_q  <= (cmd_i.op == OP_THIRD) ? third_sat :
                      ((cmd_i.op == OP_DIV && sat) ? 8'hFF : 8'h00);
            step_q <= 3'd7;
            case (cmd_i.op)
              OP_DIV:  state_q <= sat ? BK_EMIT : BK_DIV;
              OP_UNPK: state_q <= BK_UNPK;
              default: state_q <= BK_EMIT;
            endcase
          end
        end
        BK_DIV: begin
          if (hit) rem_q <= rem_q - trial;
          quo_q  <= quo_nx;
          step_q <= step_q - 3'd1;
          if (step_q == 3'd0) state_q <= BK_EMIT;
        end
        BK_EMIT: begin
          if (slot_free) begin
            out_q     <= '{kind: w_q.kind,
                           gray: (w_q.op == OP_DIRECT) ? w_q.gray : quo_q,
                           format_digit: w_q.fmt,
                           width: w_q.width, height: w_q.height, max_sample: w_q.maxs,
                           error_code: w_q.err, image_done: w_q.done, run_end: 1'b1};
            state_q   <= BK_IDLE;
          end
        end
        BK_UNPK: begin
          if (slot_free) begin
            out_q     <= '{kind: KIND_PIXEL, gray: w_q.bits[7] ? 8'd0 : 8'd255,
                           format_digit: w_q.fmt, width: w_q.width, height: w_q.height,
                           max_sample: w_q.maxs, error_code: ERR_NONE,
                           image_done: w_q.done && (w_q.cnt == 4'd1),
                           run_end: (w_q.cnt == 4'd1)};
            w_q.bits  <= {w_q.bits[6:0], 1'b0};
            w_q.cnt   <= w_q.cnt - 4'd1;
            if (w_q.cnt == 4'd1) state_q <= BK_IDLE;
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/pnm_stream_to_gray.sv
// Top level of the PNM to gray decoder: front parser, command queue, back end.
// Depends on pnm_s2g_pkg, pnm_s2g_if, pnm_s2g_front, pnm_s2g_queue, pnm_s2g_back.
//
//   channel | dir | payload                                     | handshake
//   in_i    | in  | data_byte, start_of_file                    | valid/ready
//   out_o   | out | kind, gray, format_digit, width, height,    | valid/ready
//           |     | max_sample, error_code, image_done, run_end |
//
// A byte is taken whenever the queue has room.
// A direct result (header, error, P1/P5 pixel, P3/P6 average) passes through the queue,
// the back end's command register and its result register, via its idle and emit states.
// P2 pixels also pass through the shift-subtract divider unless the quotient saturates.
// A P4 byte yields one pixel per cycle while the output is not stalled, up to 8.
// Reset clears all parser state; either side may stall, the queue decouples them.
`default_nettype none
module pnm_stream_to_gray #(
  parameter int unsigned MAX_DIM = pnm_s2g_pkg::MaxDimDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pnm_byte_if.sink   in_i,
  pnm_res_if.source  out_o
);
  import pnm_s2g_pkg::*;

  cmd_t fr_cmd, q_cmd;
  logic fr_valid, q_ready, q_valid, bk_ready;
  res_t res;

  pnm_s2g_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid), .in_data_i (in_i.data_byte), .in_sof_i (in_i.start_of_file),
    .in_ready_o (in_i.ready),
    .cmd_valid_o(fr_valid), .cmd_o (fr_cmd), .cmd_ready_i (q_ready)
  );

  pnm_s2g_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (fr_valid), .data_i (fr_cmd), .ready_o (q_ready),
    .valid_o(q_valid), .data_o (q_cmd), .pop_i (bk_ready)
  );

  pnm_s2g_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_i (q_cmd), .cmd_ready_o (bk_ready),
    .out_valid_o(out_o.valid), .out_o (res), .out_ready_i (out_o.ready)
  );

  assign out_o.kind         = res.kind;
  assign out_o.gray         = res.gray;
  assign out_o.format_digit = res.format_digit;
  assign out_o.width        = res.width;
  assign out_o.height       = res.height;
  assign out_o.max_sample   = res.max_sample;
  assign out_o.error_code   = res.error_code;
  assign out_o.image_done   = res.image_done;
  assign out_o.run_end      = res.run_end;
endmodule
`default_nettype wire

>>> design/pnm_s2g_checker.sv
// Port-level checker for pnm_stream_to_gray, bound to the top level.
// Depends on pnm_stream_to_gray_macros.svh.
`default_nettype none
`include "pnm_stream_to_gray_macros.svh"
module pnm_s2g_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  kind_i,
  input wire logic [7:0]  gray_i,
  input wire logic [2:0]  error_code_i,
  input wire logic        image_done_i,
  input wire logic        run_end_i
);
  `PNM_ASSERT_IMP(a_err_kind, clk_i, rst_ni, out_valid_i, (kind_i == 2'd2) == (error_code_i != 3'd0))
  `PNM_ASSERT_IMP(a_gray_pix, clk_i, rst_ni, out_valid_i && kind_i != 2'd0, gray_i == 8'd0)
  `PNM_ASSERT_IMP(a_done_run, clk_i, rst_ni, out_valid_i && image_done_i, kind_i == 2'd0 && run_end_i)
  `PNM_ASSERT_IMP(a_kind_ok, clk_i, rst_ni, out_valid_i, kind_i != 2'd3)
  `PNM_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(gray_i))
endmodule

bind pnm_stream_to_gray pnm_s2g_props u_checker (
  .clk_i (clk_i), .rst_ni (rst_ni),
  .out_valid_i (out_o.valid), .out_ready_i (out_o.ready),
  .kind_i (out_o.kind), .gray_i (out_o.gray), .error_code_i (out_o.error_code),
  .image_done_i (out_o.image_done), .run_end_i (out_o.run_end)
);
`default_nettype wire

>>> tb/pnm_s2g_checker.sv
// Checker for pnm_stream_to_gray: predicts the results of every byte transfer
// and compares each result transfer with the oldest prediction.
// Depends on pnm_s2g_pkg and pnm_s2g_if.
module pnm_s2g_checker #(
  parameter int unsigned MAX_DIM = pnm_s2g_pkg::MaxDimDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pnm_byte_if   bytes_i,
  pnm_res_if    res_i,
  output int    mismatches_o,
  output int    pending_o,
  output int    headers_o,
  output int    pixels_o,
  output int    errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pnm_s2g_pkg::*;

  typedef enum {
    S_MAGIC_P, S_MAGIC_NUM, S_HEADER, S_DATA, S_DONE, S_ERROR
  } parse_e;

  parse_e          ph;
  int unsigned     fmt, wid, hgt, maxv, acc, step, cmt, col, ssum, comp, half;
  longint unsigned pcnt;
  int              new_cnt;
  res_t            decoded_q[$];
  int              mismatches = 0;
  int              n_hdr = 0, n_pix = 0, n_err = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = decoded_q.size();
  assign headers_o    = n_hdr;
  assign pixels_o     = n_pix;
  assign errors_o     = n_err;

  function automatic bit is_ws(int unsigned c);
    return c == 32 || (c >= 9 && c <= 13);
  endfunction

  function automatic bit is_digit(int unsigned c);
    return c >= 48 && c <= 57;
  endfunction

  function void clear_state();
    ph = S_MAGIC_P;
    fmt = 0; wid = 0; hgt = 0; maxv = 0; acc = 0; step = 0; cmt = 0;
    col = 0; ssum = 0; comp = 0; half = 0; pcnt = 0;
  endfunction

  initial clear_state();

  function void push(logic [1:0] kind, int unsigned gray, logic [2:0] err, bit done);
    res_t r;
    r.kind         = kind;
    r.gray         = gray[7:0];
    r.format_digit = fmt[2:0];
    r.width        = wid[14:0];
    r.height       = hgt[14:0];
    r.max_sample   = maxv[15:0];
    r.error_code   = err;
    r.image_done   = done;
    r.run_end      = 1'b0;
    decoded_q.push_back(r);
    new_cnt++;
  endfunction

  function void flag(logic [2:0] code);
    ph = S_ERROR;
    push(KIND_ERROR, 0, code, 1'b0);
  endfunction

  function void emit_pixel(int unsigned g);
    longint unsigned total;
    bit done;
    total = longint'(wid) * longint'(hgt);
    done = 1'b0;
    if (pcnt + 1 >= total) begin
      done = 1'b1;
      ph = S_DONE;
    end else begin
      pcnt++;
    end
    push(KIND_PIXEL, g, ERR_NONE, done);
  endfunction

  function void header_char(int unsigned c);
    int unsigned target, v;
    target = (fmt == 1 || fmt == 4) ? 4 : 6;
    if (!step[0] && !is_ws(c)) step++;
    if (!step[0]) return;
    if (is_digit(c)) begin
      v = acc * 10 + (c - 48);
      if (step == 5) begin
        if (v > 65535) begin flag(ERR_MAXVAL); return; end
      end else if (v > MAX_DIM) begin
        flag(ERR_DIM);
        return;
      end
      acc = v;
      return;
    end
    if (!is_ws(c)) begin flag(ERR_CHAR); return; end
    if (step == 1) wid = acc;
    else if (step == 3) hgt = acc;
    else if (acc == 0) begin flag(ERR_MAXVAL); return; end
    else maxv = acc;
    acc = 0;
    step++;
    if (step >= target) begin
      if (target == 4) maxv = 1;
      step = 0; pcnt = 0; col = 0; ssum = 0; comp = 0; half = 0;
      ph = (wid == 0 || hgt == 0) ? S_DONE : S_DATA;
      push(KIND_HEADER, 0, ERR_NONE, 1'b0);
    end
  endfunction

  function void ascii_char(int unsigned c);
    int unsigned g;
    if (is_digit(c)) begin
      if (fmt == 1) begin emit_pixel(c == 48 ? 255 : 0); return; end
      acc = acc * 10 + (c - 48);
      if (acc > 32'h1FFFF) acc = 32'h1FFFF;
      step = 1;
      return;
    end
    if (!is_ws(c)) begin flag(ERR_CHAR); return; end
    if (fmt == 1 || step == 0) return;
    if (fmt == 2) begin
      g = (maxv != 0) ? acc * 255 / maxv : 255;
      emit_pixel(g > 255 ? 255 : g);
    end else begin
      ssum += acc;
      if (ssum > 32'h3FFFF) ssum = 32'h3FFFF;
      comp++;
      if (comp >= 3) begin
        g = ssum / 3;
        ssum = 0;
        comp = 0;
        emit_pixel(g > 255 ? 255 : g);
      end
    end
    acc = 0;
    step = 0;
  endfunction

  function void raw_byte(int unsigned c);
    int unsigned left, cnt;
    if (fmt == 4) begin
      left = wid - col;
      cnt = left < 8 ? left : 8;
      for (int i = 0; i < cnt && ph == S_DATA; i++)
        emit_pixel(((c << i) & 128) != 0 ? 0 : 255);
      col += cnt;
      if (col >= wid) col = 0;
      return;
    end
    if (maxv > 255) begin
      // keep the most significant byte of a two-byte sample
      if (half == 1) begin
        half = 0;
        c = acc & 255;
      end else begin
        half = 1;
        acc = c;
        return;
      end
    end
    if (fmt == 5) begin emit_pixel(c); return; end
    ssum += c;
    comp++;
    if (comp >= 3) begin
      emit_pixel(ssum / 3);
      ssum = 0;
      comp = 0;
    end
  endfunction

  function void decode_byte(logic [7:0] data, logic sof);
    int unsigned c;
    c = data;
    new_cnt = 0;
    if (sof) clear_state();
    case (ph)
      S_MAGIC_P: begin
        if (c == 80) ph = S_MAGIC_NUM;
        else flag(ERR_MAGIC);
      end
      S_MAGIC_NUM: begin
        if (c >= 49 && c <= 54) begin
          fmt = c - 48;
          ph = S_HEADER;
        end else begin
          flag(ERR_MAGIC);
        end
      end
      S_HEADER, S_DATA: begin
        if (ph == S_HEADER || fmt <= 3) begin
          if (cmt != 0) begin
            if (c == 10) cmt = 0;
          end else if (c == 35) begin
            cmt = 1;
          end else if (ph == S_HEADER) begin
            header_char(c);
          end else begin
            ascii_char(c);
          end
        end else begin
          raw_byte(c);
        end
      end
      default: ;
    endcase
    if (new_cnt > 0) decoded_q[decoded_q.size() - 1].run_end = 1'b1;
  endfunction

  function automatic int field_bad(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  function void compare_result();
    res_t want;
    int bad;
    if (decoded_q.size() == 0) begin
      $display("%0t: result transfer with nothing predicted, kind %0d", $time, res_i.kind);
      mismatches++;
      return;
    end
    want = decoded_q.pop_front();
    bad = field_bad("kind", want.kind, res_i.kind)
        + field_bad("gray", want.gray, res_i.gray)
        + field_bad("format_digit", want.format_digit, res_i.format_digit)
        + field_bad("width", want.width, res_i.width)
        + field_bad("height", want.height, res_i.height)
        + field_bad("max_sample", want.max_sample, res_i.max_sample)
        + field_bad("error_code", want.error_code, res_i.error_code)
        + field_bad("image_done", want.image_done, res_i.image_done)
        + field_bad("run_end", want.run_end, res_i.run_end);
    mismatches += bad;
    case (want.kind)
      KIND_PIXEL:  n_pix++;
      KIND_HEADER: n_hdr++;
      default:     n_err++;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (bytes_i.valid && bytes_i.ready) decode_byte(bytes_i.data_byte, bytes_i.start_of_file);
      if (res_i.valid && res_i.ready) compare_result();
    end
  end

endmodule

>>> tb/pnm_stream_to_gray_tb.sv
// Testbench top for pnm_stream_to_gray: builds PNM files of every format,
// broken ones too, streams them with random gaps and stalls, and gives the verdict.
// Depends on pnm_s2g_pkg, pnm_s2g_if, pnm_s2g_checker and the block.
module pnm_stream_to_gray_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned RandomBytes = 160;

  typedef struct {
    logic [7:0] data;
    logic       sof;
  } file_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pnm_byte_if bytes_ch ();
  pnm_res_if  res_ch ();

  int mismatches, pending, n_hdr, n_pix, n_err;
  int sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  file_byte_t file_q[$];

  pnm_stream_to_gray dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (bytes_ch),
    .out_o  (res_ch)
  );

  pnm_s2g_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bytes_i      (bytes_ch),
    .res_i        (res_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .headers_o    (n_hdr),
    .pixels_o     (n_pix),
    .errors_o     (n_err)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((bytes_ch.valid && bytes_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side: random stall per transfer, one long hold-off on request
  initial begin
    int unsigned n;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = calm ? 0 : $urandom_range(0, 7);
      if (hold_req) begin
        n = LongHold;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        res_ch.ready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      res_ch.ready = 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  function void put_b(int unsigned b, bit sof);
    file_byte_t fb;
    fb.data = b[7:0];
    fb.sof  = sof;
    file_q.push_back(fb);
  endfunction

  function void put_str(string s);
    foreach (s[i]) put_b(s[i], 1'b0);
  endfunction

  function void put_num(int unsigned v);
    if ($urandom_range(0, 9) == 0) put_b(8'h30, 1'b0);
    put_str($sformatf("%0d", v));
  endfunction

  function void put_ws();
    int unsigned pick[6] = '{32, 9, 10, 11, 12, 13};
    put_b(pick[$urandom_range(0, 5)], 1'b0);
  endfunction

  function void put_sep();
    put_ws();
    if ($urandom_range(0, 5) == 0) begin
      put_str("# x P9\t");
      put_b(10, 1'b0);
    end
    if ($urandom_range(0, 2) == 0) put_ws();
  endfunction

  function void make_file(int unsigned f, int unsigned w, int unsigned h,
                          int unsigned mv, bit corrupt);
    int unsigned cnt, v;
    put_b(8'h50, 1'b1);
    put_b(8'h30 + f, 1'b0);
    put_sep();
    put_num(w);
    put_sep();
    put_num(h);
    if (f != 1 && f != 4) begin
      put_sep();
      put_num(mv);
    end
    put_ws();
    case (f)
      1: for (int i = 0; i < w * h; i++) begin
        if ($urandom_range(0, 2) == 0) put_sep();
        v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : $urandom_range(0, 1);
        put_b(8'h30 + v, 1'b0);
      end
      2, 3: for (int i = 0; i < w * h * (f == 3 ? 3 : 1); i++) begin
        v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 999999) : $urandom_range(0, mv);
        put_num(v);
        put_sep();
      end
      4: for (int i = 0; i < h * ((w + 7) / 8); i++) put_b($urandom_range(0, 255), 1'b0);
      default: begin
        cnt = w * h * (f == 6 ? 3 : 1) * (mv > 255 ? 2 : 1);
        for (int i = 0; i < cnt; i++) put_b($urandom_range(0, 255), 1'b0);
      end
    endcase
    if (corrupt && file_q.size() > 1)
      file_q[$urandom_range(1, file_q.size() - 1)].data = $urandom_range(0, 255);
    // trailing junk is ignored once the image is done
    if ($urandom_range(0, 5) == 0) put_b($urandom_range(0, 255), 1'b0);
  endfunction

  task automatic send_file();
    int unsigned gap;
    foreach (file_q[i]) begin
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        bytes_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      bytes_ch.valid         = 1'b1;
      bytes_ch.data_byte     = file_q[i].data;
      bytes_ch.start_of_file = file_q[i].sof;
      @(posedge clk_i);
      while (!bytes_ch.ready) @(posedge clk_i);
      @(negedge clk_i);
      sent++;
    end
    bytes_ch.valid = 1'b0;
    file_q.delete();
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_maxval();
    case ($urandom_range(0, 5))
      0: return 1;
      1: return 255;
      2: return 65535;
      3: return $urandom_range(256, 65535);
      default: return $urandom_range(1, 255);
    endcase
  endfunction

  initial begin
    int unsigned f, w, h;
    bytes_ch.valid         = 1'b0;
    bytes_ch.data_byte     = 8'h00;
    bytes_ch.start_of_file = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: bad magic, header errors, empty image, saturation, padding
    put_b(8'h51, 1'b1);                      send_file();
    put_b(8'h50, 1'b1); put_str("7");        send_file();
    put_b(8'h50, 1'b1); put_str("5 16385");  send_file();
    put_b(8'h50, 1'b1); put_str("2 1 1 0 "); send_file();
    put_b(8'h50, 1'b1); put_str("2 1 1 65536"); send_file();
    put_b(8'h50, 1'b1); put_str("2 1 x");    send_file();
    put_b(8'h50, 1'b1); put_str("5 0 3 255 "); send_file();
    put_b(8'h50, 1'b1); put_str("1\n#c\n2 1\n01"); send_file();
    put_b(8'h50, 1'b1); put_str("4 9 1 "); put_b(8'hFF, 1'b0); put_b(8'h00, 1'b0);
    send_file();
    put_b(8'h50, 1'b1); put_str("2 1 1 1 9999999 "); send_file();
    put_b(8'h50, 1'b1); put_str("3 1 1 65535 65535 65535 65535 "); send_file();
    put_b(8'h50, 1'b1); put_str("6 1 1 65535 ");
    for (int i = 0; i < 6; i++) put_b(i[0] ? 8'h00 : 8'hFF, 1'b0);
    send_file();
    drain();

    hold_req = 1'b1;
    sent = 0;
    while (sent < RandomBytes) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: for (int i = 0; i < $urandom_range(1, 4); i++)
             put_b($urandom_range(0, 255), i == 0);
        1: begin
          put_b(8'h50, 1'b1);
          put_b(8'h30 + $urandom_range(1, 6), 1'b0);
          put_ws();
          case ($urandom_range(0, 2))
            0: put_num($urandom_range(16385, 30000));
            1: begin put_str("2 2 "); put_num($urandom_range(0, 1) ? 0 : 70000); put_ws(); end
            default: begin put_str("3"); put_b($urandom_range(0, 255), 1'b0); end
          endcase
        end
        default: begin
          f = $urandom_range(1, 6);
          w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
          h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
          make_file(f, w, h, pick_maxval(), $urandom_range(0, 7) == 0);
        end
      endcase
      send_file();
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (50) @(negedge clk_i);
    $display("Streamed %0d random bytes after the directed files over all six formats;",
             sent);
    $display("checked %0d headers, %0d pixels and %0d error results.", n_hdr, n_pix, n_err);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
